/* rtl/lpmd_pkg.sv */
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants of the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Reset values of the length window.
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd17;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd512;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

    // Framing phase, one-hot.
    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_offset;
        logic [LEN_W-1:0]  message_length;
        logic              last_of_message;
        logic              malformed;
    } result_t;

endpackage

/* rtl/lpmd_stream_if.sv */
// ----------------------------------------------------------------------------
// lpmd_stream_if / lpmd_msg_if
// Valid/ready channels for stream bytes in and message words out.
// ----------------------------------------------------------------------------
interface lpmd_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_stream;

    modport source (output valid, output in_byte, output new_stream, input ready);
    modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lpmd_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic [15:0] message_length;
    logic        last_of_message;
    logic        malformed;

    modport source (output valid, output payload_byte, output byte_offset,
                    output message_length, output last_of_message,
                    output malformed, input ready);
    modport sink   (input valid, input payload_byte, input byte_offset,
                    input message_length, input last_of_message,
                    input malformed, output ready);
endinterface

/* rtl/lpmd_parser.sv */
// ----------------------------------------------------------------------------
// lpmd_parser
// Input register, framing state and the per-byte parse step.
// ----------------------------------------------------------------------------
module lpmd_parser
    import lpmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    lpmd_stream_if.sink        stream,
    input  logic [LEN_W-1:0]   min_len,
    input  logic [LEN_W-1:0]   max_len,
    output logic               res_valid,
    output result_t            res,
    input  logic               res_ready
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_new_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;
    logic [LEN_W-1:0]  current_length_reg, current_length_next;
    logic [LEN_W-1:0]  bytes_seen_reg, bytes_seen_next;
    logic              error_stuck_reg, error_stuck_next;

    phase_t            ph_eff;
    logic [BYTE_W-1:0] hi_eff;
    logic [LEN_W-1:0]  len_eff;
    logic [LEN_W-1:0]  seen_eff;
    logic              err_eff;
    logic [LEN_W-1:0]  rx_len;
    logic [LEN_W:0]    seen_inc;
    logic              is_last;
    logic              advance;
    logic              item_has_result;

    assign advance      = s1_valid_reg && (!item_has_result || res_ready);
    assign stream.ready = !s1_valid_reg || advance;
    assign res_valid    = s1_valid_reg && item_has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_byte_reg <= stream.in_byte;
            s1_new_reg  <= stream.new_stream;
        end
    end

    // A new stream clears the session before its byte is parsed.
    always_comb
    begin
        ph_eff   = s1_new_reg ? PH_HIGH : phase_reg;
        hi_eff   = s1_new_reg ? '0 : length_high_reg;
        len_eff  = s1_new_reg ? '0 : current_length_reg;
        seen_eff = s1_new_reg ? '0 : bytes_seen_reg;
        err_eff  = s1_new_reg ? 1'b0 : error_stuck_reg;
    end

    assign rx_len   = {hi_eff, s1_byte_reg};
    assign seen_inc = {1'b0, seen_eff} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last  = seen_inc >= {1'b0, len_eff};

    always_comb
    begin
        phase_next          = ph_eff;
        length_high_next    = hi_eff;
        current_length_next = len_eff;
        bytes_seen_next     = seen_eff;
        error_stuck_next    = err_eff;
        item_has_result     = 1'b0;
        res                 = '0;

        if (!err_eff)
        begin
            unique case (ph_eff)
                PH_LOW:
                begin
                    if ((rx_len < min_len) || (rx_len > max_len))
                    begin
                        error_stuck_next   = 1'b1;
                        phase_next         = PH_HIGH;
                        item_has_result    = 1'b1;
                        res.message_length = rx_len;
                        res.malformed      = 1'b1;
                    end
                    else
                    begin
                        current_length_next = rx_len;
                        bytes_seen_next     = '0;
                        phase_next          = (rx_len == '0) ? PH_HIGH : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    item_has_result     = 1'b1;
                    res.payload_byte    = s1_byte_reg;
                    res.byte_offset     = seen_eff;
                    res.message_length  = len_eff;
                    res.last_of_message = is_last;
                    bytes_seen_next     = seen_inc[LEN_W-1:0];
                    if (is_last)
                    begin
                        phase_next = PH_HIGH;
                    end
                end
                default:
                begin
                    length_high_next = s1_byte_reg;
                    phase_next       = PH_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HIGH;
            length_high_reg    <= '0;
            current_length_reg <= '0;
            bytes_seen_reg     <= '0;
            error_stuck_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            current_length_reg <= current_length_next;
            bytes_seen_reg     <= bytes_seen_next;
            error_stuck_reg    <= error_stuck_next;
        end
    end

    a_stuck_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (error_stuck_reg && s1_valid_reg && !s1_new_reg) |-> !res_valid)
        else $error("result produced while the stream is in error");

    a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (bytes_seen_reg < current_length_reg))
        else $error("payload count reached the declared length inside a body");

    a_last_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.last_of_message) |=> (phase_reg == PH_HIGH))
        else $error("last payload word did not return to the length phase");

    a_stuck_phase: assert property (@(posedge clk) disable iff (!rst_n)
        error_stuck_reg |-> (phase_reg == PH_HIGH))
        else $error("error state with framing phase not at the length start");

endmodule

/* rtl/lpmd_out_reg.sv */
// ----------------------------------------------------------------------------
// lpmd_out_reg
// Result register driving the message channel.
// ----------------------------------------------------------------------------
module lpmd_out_reg
    import lpmd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  result_t      res,
    output logic         res_ready,
    lpmd_msg_if.source   msg
);

    logic    valid_reg;
    result_t data_reg;

    assign res_ready = !valid_reg || msg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

    assign msg.valid           = valid_reg;
    assign msg.payload_byte    = data_reg.payload_byte;
    assign msg.byte_offset     = data_reg.byte_offset;
    assign msg.message_length  = data_reg.message_length;
    assign msg.last_of_message = data_reg.last_of_message;
    assign msg.malformed       = data_reg.malformed;

endmodule

/* rtl/length_prefix_message_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefix_message_deframer
// Splits a reassembled byte stream into messages that open with a 16-bit
// big-endian length, and forwards the payload bytes cut-through.
// ----------------------------------------------------------------------------
// Usage:
// The stream channel takes one word per byte: in_byte and new_stream, where
// new_stream clears the session before its byte is parsed. The msg channel
// gives one word per payload byte with its offset, the declared length and a
// last mark, or one malformed word when a length falls outside
// [min_len, max_len]; after that the stream drops every byte until the next
// new_stream. Length bytes and dropped bytes give no word. A message may be
// cut short by a new stream, so a consumer discards any message whose last
// mark never came.
// After its stream word is accepted, a msg word passes the input register and
// then the result register, which takes the combinational parse result.
// Throughput is one byte per cycle while the receiver takes words, set by the
// combinational parse step that updates the framing state. When the receiver
// stalls, the result register holds its word and the input register keeps
// taking bytes until it holds one that owes a word; after that stream.ready
// drops. Reset empties both registers, returns the framing to the length high
// byte, clears the error state and loads min_len = 17 and max_len = 512.
// cfg_we writes register cfg_index (0 min_len, 1 max_len).
// ----------------------------------------------------------------------------
module length_prefix_message_deframer
    import lpmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lpmd_stream_if.sink          stream,
    lpmd_msg_if.source           msg,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    // Length window registers.
    logic [LEN_W-1:0] min_len_reg;
    logic [LEN_W-1:0] max_len_reg;

    // Parse step to result register.
    logic    res_valid;
    logic    res_ready;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_LEN: min_len_reg <= cfg_data;
                REG_MAX_LEN: max_len_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Input register, framing state and the per-byte parse.
    lpmd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .min_len   (min_len_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Result register that holds a word while the receiver stalls.
    lpmd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .msg       (msg)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefix_message_deframer. Stream bytes are
// sent as framed messages, broken frames and noise under several length
// windows. Every msg word is compared against a cycle-free model of the
// framing rules, while both channels idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;
    import lpmd_pkg::*;

    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LEN_SPAN      = 40;

    // ------------------------------------------------------------------------
    // Framing model and store of the msg words still owed by the block.
    // ------------------------------------------------------------------------
    class deframer_scoreboard;
        logic [LEN_W-1:0]  len_floor;
        logic [LEN_W-1:0]  len_ceiling;
        phase_t            frame_phase;
        logic [BYTE_W-1:0] len_msb;
        logic [LEN_W-1:0]  msg_len;
        logic [LEN_W-1:0]  msg_offset;
        bit                stuck;
        result_t           owed_words[$];
        int unsigned       mismatches;
        int unsigned       words_checked;
        int unsigned       malformed_words;
        int unsigned       messages_closed;

        function new();
            len_floor       = MIN_LEN_RESET;
            len_ceiling     = MAX_LEN_RESET;
            mismatches      = 0;
            words_checked   = 0;
            malformed_words = 0;
            messages_closed = 0;
            clear_session();
        endfunction

        function void clear_session();
            frame_phase = PH_HIGH;
            len_msb     = '0;
            msg_len     = '0;
            msg_offset  = '0;
            stuck       = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
            if (idx == REG_MIN_LEN)
                len_floor = value;
            else if (idx == REG_MAX_LEN)
                len_ceiling = value;
        endfunction

        // Applies one accepted stream word to the framing state and queues
        // the msg word that it causes, if any.
        function void note_byte(logic [BYTE_W-1:0] b, logic fresh);
            logic [LEN_W-1:0] len;
            result_t          word;
            word = '0;
            if (fresh)
                clear_session();
            if (stuck)
                return;
            case (frame_phase)
                PH_LOW:
                begin
                    len = {len_msb, b};
                    if (len < len_floor || len > len_ceiling) begin
                        stuck               = 1'b1;
                        frame_phase         = PH_HIGH;
                        word.message_length = len;
                        word.malformed      = 1'b1;
                        owed_words.push_back(word);
                    end
                    else begin
                        msg_len     = len;
                        msg_offset  = '0;
                        frame_phase = (len == '0) ? PH_HIGH : PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    word.payload_byte    = b;
                    word.byte_offset     = msg_offset;
                    word.message_length  = msg_len;
                    word.last_of_message = ({16'd0, msg_offset} + 32'd1) >= {16'd0, msg_len};
                    owed_words.push_back(word);
                    msg_offset = msg_offset + 1'b1;
                    if (word.last_of_message)
                        frame_phase = PH_HIGH;
                end
                default:
                begin
                    len_msb     = b;
                    frame_phase = PH_LOW;
                end
            endcase
        endfunction

        function void report_mismatch(string what);
            $display("testbench: mismatch at %0t ns: %s", $time, what);
            mismatches++;
        endfunction

        function void compare_field(string name, logic [LEN_W-1:0] got,
                                    logic [LEN_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %0d %s is 0x%0h, expected 0x%0h",
                                          words_checked, name, got, want));
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("msg word %p arrived with none owed", got));
                return;
            end
            want = owed_words.pop_front();
            compare_field("payload_byte", LEN_W'(got.payload_byte),
                          LEN_W'(want.payload_byte));
            compare_field("byte_offset", got.byte_offset, want.byte_offset);
            compare_field("message_length", got.message_length, want.message_length);
            compare_field("last_of_message", LEN_W'(got.last_of_message),
                          LEN_W'(want.last_of_message));
            compare_field("malformed", LEN_W'(got.malformed), LEN_W'(want.malformed));
            words_checked++;
            if (want.malformed)
                malformed_words++;
            if (want.last_of_message)
                messages_closed++;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    lpmd_stream_if stream_ch ();
    lpmd_msg_if    msg_ch ();

    deframer_scoreboard board;

    // Idling switches; each phase of the run turns them on or off.
    bit          src_gaps;
    bit          sink_stalls;
    int unsigned bytes_sent;

    length_prefix_message_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_ch),
        .msg       (msg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // All inputs are known from time zero.
    initial begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_MIN_LEN;
        cfg_data             = '0;
        stream_ch.valid      = 1'b0;
        stream_ch.in_byte    = '0;
        stream_ch.new_stream = 1'b0;
        msg_ch.ready         = 1'b0;
        src_gaps             = 1'b0;
        sink_stalls          = 1'b0;
        bytes_sent           = 0;
        board                = new();
    end

    // The receiver side. Ready changes at the falling edge. When stalls are
    // enabled, a stall starts now and then.
    initial begin : msg_receiver
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                msg_ch.ready = 1'b0;
                stall_left--;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                msg_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 17) - 1;
            end
            else begin
                msg_ch.ready = 1'b1;
            end
        end
    end

    // Every accepted msg word is checked at the rising edge, where the
    // values seen are the ones that the handshake took.
    always @(posedge clk) begin : msg_watch
        result_t seen_word;
        if (rst_n && msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1) begin
            seen_word.payload_byte    = msg_ch.payload_byte;
            seen_word.byte_offset     = msg_ch.byte_offset;
            seen_word.message_length  = msg_ch.message_length;
            seen_word.last_of_message = msg_ch.last_of_message;
            seen_word.malformed       = msg_ch.malformed;
            board.check_word(seen_word);
        end
    end

    // Sends one stream word. Called at a falling edge and returns at the
    // falling edge after the handshake, with valid still high so that a
    // following word can go out back to back.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fresh);
        int unsigned gap;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap             = $urandom_range(1, 17);
            stream_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_ch.valid      = 1'b1;
        stream_ch.in_byte    = b;
        stream_ch.new_stream = fresh;
        do
            @(posedge clk);
        while (stream_ch.ready !== 1'b1);
        board.note_byte(b, fresh);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Waits until every owed word has come, then lets the pipeline settle,
    // since length bytes may still be in flight without any word owed.
    task automatic wait_quiet();
        int unsigned spins;
        stream_ch.valid = 1'b0;
        spins = 0;
        while (board.owed_words.size() != 0 && spins < DRAIN_LIMIT) begin
            @(negedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        board.write_reg(idx, value);
    endtask

    // The length window may only move while the block is quiet.
    task automatic set_window(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
        wait_quiet();
        write_reg(REG_MIN_LEN, lo);
        write_reg(REG_MAX_LEN, hi);
    endtask

    // Sends a length header and then up to cut payload bytes. A header that
    // follows a broken or stuck stream opens a new stream. A rejected length
    // is followed by up to three bytes that the error state must swallow.
    task automatic send_frame(input int unsigned len, input int unsigned cut);
        bit          fresh;
        int unsigned n;
        fresh = board.stuck || board.frame_phase != PH_HIGH || $urandom_range(0, 9) == 0;
        send_byte(len[15:8], fresh);
        send_byte(len[7:0], 1'b0);
        if (len >= board.len_floor && len <= board.len_ceiling)
            n = (cut < len) ? cut : len;
        else
            n = $urandom_range(0, 3);
        repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // Picks a length inside the current window, kept short so that runs
    // stay small; with an empty window any length will do.
    function automatic int unsigned length_in_window();
        int unsigned lo;
        int unsigned hi;
        lo = board.len_floor;
        hi = board.len_ceiling;
        if (lo > hi)
            return $urandom_range(0, 16'hFFFF);
        if (hi > lo + LEN_SPAN)
            hi = lo + LEN_SPAN;
        return $urandom_range(lo, hi);
    endfunction

    // Picks a length outside the current window, below or above it, or inside it when no length lies outside.
    function automatic int unsigned length_outside_window();
        int unsigned lo;
        int unsigned hi;
        lo = board.len_floor;
        hi = board.len_ceiling;
        if (lo > 0 && (hi == 16'hFFFF || $urandom_range(0, 1) == 0))
            return $urandom_range(0, lo - 1);
        if (hi < 16'hFFFF)
            return $urandom_range(hi + 1, 16'hFFFF);
        return length_in_window();
    endfunction

    // Mostly whole messages with random content; the rest is rejected
    // lengths, messages cut short by a new stream, and loose noise bytes.
    task automatic run_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = length_in_window();
                send_frame(len, len);
            end
            else if (pick < 80) begin
                send_frame(length_outside_window(), 0);
            end
            else if (pick < 90) begin
                len = length_in_window();
                send_frame(len, $urandom_range(0, len));
            end
            else begin
                repeat ($urandom_range(1, 4))
                    send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset window 17..512: a length of 16 is one short, so the stream
        // reports it and then sticks, dropping the byte after it.
        send_byte(8'h00, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'hFF, 1'b0);

        // Window 0..2: a zero length gives no word and the next byte starts
        // a new header. Then a two-byte message with extreme payload values,
        // a length of 3 that is too long, and a dropped byte.
        set_window(16'd0, 16'd2);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        // A new stream lands between the two length bytes, and the length
        // it starts has its top bit set, which is far out of range.
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
        // A one-byte message after the error has been cleared.
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hA5, 1'b0);

        // Window pinned at the largest length: the header is accepted and a
        // couple of payload bytes flow before the message is abandoned.
        set_window(16'hFFFF, 16'hFFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);

        // Minimum above maximum: every length is rejected.
        set_window(16'd5, 16'd4);
        send_byte(8'h00, 1'b1);
        send_byte(8'h04, 1'b0);

        // Random traffic across windows, with idling on one or both sides in most
        // phases and a quiet final stretch.
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        set_window(16'd17, 16'd512);
        run_traffic(90);
        set_window(16'd0, 16'd40);
        run_traffic(90);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        set_window(16'd0, 16'd0);
        run_traffic(40);
        src_gaps = 1'b1;
        set_window(16'd1, 16'd8);
        run_traffic(90);
        src_gaps    = 1'b0;
        sink_stalls = 1'b1;
        set_window(16'hFFFF, 16'd0);
        run_traffic(50);
        src_gaps = 1'b1;
        set_window(16'd3, 16'hFFFF);
        run_traffic(90);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        set_window(16'd17, 16'd512);
        run_traffic(100);

        // Let the last words drain; anything still owed is a failure.
        wait_quiet();
        if (board.owed_words.size() != 0)
            board.report_mismatch($sformatf("%0d msg words never arrived",
                                            board.owed_words.size()));

        $display("testbench: %0d stream bytes sent, %0d msg words checked",
                 bytes_sent, board.words_checked);
        $display("testbench: %0d messages closed, %0d malformed lengths, %0d mismatches",
                 board.messages_closed, board.malformed_words, board.mismatches);
        if (board.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("testbench: timeout, stream or msg channel hung");
        $display("testbench: FAIL");
        $finish;
    end

endmodule
